// ===== hw/rtl/shamir_share_generator_unit_defines.svh =====
// Assertion macros used by the share generator evaluator (ssg_eval).
`ifndef SHAMIR_SHARE_GENERATOR_UNIT_DEFINES_SVH
`define SHAMIR_SHARE_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSG_ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SSG_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ssg_pkg.sv =====
// Types and constants of the share generator.
`default_nettype none

package ssg_pkg;

	localparam int WORD_W  = 32;
	localparam int POINT_W = 5;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_FIELD_MODE     = 3'd0;
	localparam logic [2:0] REG_PRIME_MODULUS  = 3'd1;
	localparam logic [2:0] REG_FIELD_DEGREE   = 3'd2;
	localparam logic [2:0] REG_REDUCTION_POLY = 3'd3;
	localparam logic [2:0] REG_THRESHOLD      = 3'd4;
	localparam logic [2:0] REG_SHARE_COUNT    = 3'd5;

	typedef struct packed {
		logic [WORD_W-1:0] coeff_value;
	} coeff_word_t;

	typedef struct packed {
		logic [WORD_W-1:0]  share_value;
		logic [POINT_W-1:0] share_point;
		logic               last_share;
	} share_word_t;

	// field settings as seen by the evaluator, already clamped
	typedef struct packed {
		logic               binary;
		logic [WORD_W-1:0]  modulus;
		logic [5:0]         degree;
		logic [WORD_W-1:0]  mask;
		logic [WORD_W-1:0]  poly;
		logic [POINT_W-1:0] points;
	} field_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssg_stream_if.sv =====
// Valid/ready stream channel carrying one word.
`default_nettype none

interface ssg_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssg_cell.sv =====
// One coefficient cell of the load/rotate chain.
`default_nettype none

module ssg_cell (
	input  wire logic        clk,
	input  wire logic        load,
	input  wire logic        rot,
	input  wire logic [31:0] ld_in,
	input  wire logic [31:0] rot_in,
	output logic      [31:0] q
);

	logic [31:0] word_q;

	always_ff @(posedge clk) begin
		priority if (load) begin
			word_q <= ld_in;
		end else if (rot) begin
			word_q <= rot_in;
		end
	end

	assign q = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ssg_eval.sv =====
// Bit-serial Horner evaluator with share output register.
`default_nettype none
`include "shamir_share_generator_unit_defines.svh"

module ssg_eval #(
	parameter int K_MAX = 8,
	localparam int CW = $clog2(K_MAX + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ssg_pkg::field_cfg_t cfg,
	input  wire logic               start,
	input  wire logic [CW-1:0]      used,
	input  wire logic [31:0]        coeff,
	output logic                    rot,
	output logic [CW-1:0]           ring_len,
	output logic                    busy,
	ssg_stream_if.source            share_out
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CRED = 3'd1;
	localparam logic [2:0] S_DBL  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_CADD = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]    state_q;
	logic [4:0]    step_q;
	logic [2:0]    bit_q;
	logic [CW-1:0] ci_q;
	logic [CW-1:0] used_q;
	logic [4:0]    pt_q;
	logic          out_valid_q;
	logic [31:0]   acc_q, r_q, cr_q;
	ssg_pkg::share_word_t out_q;
	logic          emit_ok, is_last;

	// s < 2p -> s mod p
	function automatic logic [31:0] p_fix(logic [32:0] s, logic [31:0] p);
		logic [32:0] t;
		t = s;
		if (t >= {1'b0, p}) begin
			t = t - {1'b0, p};
		end
		return t[31:0];
	endfunction

	// multiply by x modulo x^m + poly
	function automatic logic [31:0] xtime(logic [31:0] r, logic [5:0] m, logic [31:0] poly);
		logic [32:0] t;
		logic [32:0] top;
		t   = {r, 1'b0};
		top = 33'd1 << m;
		if ((t & top) != 33'd0) begin
			t = t ^ (top | {1'b0, poly});
		end
		return t[31:0];
	endfunction

	assign emit_ok  = !out_valid_q || share_out.ready;
	assign is_last  = (pt_q == cfg.points);
	assign rot      = (state_q == S_CADD);
	assign busy     = (state_q != S_IDLE);
	assign ring_len = used_q;
	assign share_out.valid = out_valid_q;
	assign share_out.data  = out_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			bit_q       <= '0;
			ci_q        <= '0;
			used_q      <= '0;
			pt_q        <= '0;
		end else begin
			if (state_q == S_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (share_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						used_q  <= used;
						ci_q    <= used;
						pt_q    <= 5'd1;
						step_q  <= '0;
						bit_q   <= 3'd4;
						state_q <= S_CRED;
					end
				end
				S_CRED: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= S_DBL;
					end
				end
				S_DBL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (bit_q == 3'd0) begin
						state_q <= S_CADD;
					end else begin
						bit_q   <= bit_q - 3'd1;
						state_q <= S_DBL;
					end
				end
				S_CADD: begin
					if (ci_q == CW'(1)) begin
						state_q <= S_EMIT;
					end else begin
						ci_q    <= ci_q - CW'(1);
						step_q  <= '0;
						bit_q   <= 3'd4;
						state_q <= S_CRED;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							pt_q    <= pt_q + 5'd1;
							ci_q    <= used_q;
							step_q  <= '0;
							bit_q   <= 3'd4;
							state_q <= S_CRED;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				r_q   <= '0;
				cr_q  <= '0;
			end
			S_CRED: begin
				// coefficient mod p, one bit a cycle, msb first; the binary field masks it
				if (cfg.binary) begin
					cr_q <= coeff & cfg.mask;
				end else begin
					cr_q <= p_fix({cr_q, coeff[~step_q]}, cfg.modulus);
				end
			end
			S_DBL: begin
				if (cfg.binary) begin
					r_q <= xtime(r_q, cfg.degree, cfg.poly);
				end else begin
					r_q <= p_fix({1'b0, r_q} + {1'b0, r_q}, cfg.modulus);
				end
			end
			S_ADD: begin
				if (pt_q[bit_q]) begin
					if (cfg.binary) begin
						r_q <= r_q ^ acc_q;
					end else begin
						r_q <= p_fix({1'b0, r_q} + {1'b0, acc_q}, cfg.modulus);
					end
				end
			end
			S_CADD: begin
				if (cfg.binary) begin
					acc_q <= r_q ^ cr_q;
				end else begin
					acc_q <= p_fix({1'b0, r_q} + {1'b0, cr_q}, cfg.modulus);
				end
				r_q  <= '0;
				cr_q <= '0;
			end
			S_EMIT: begin
				if (emit_ok) begin
					out_q.share_value <= (!cfg.binary && cfg.modulus < 32'd2) ? '0 : acc_q;
					out_q.share_point <= pt_q;
					out_q.last_share  <= is_last;
					acc_q <= '0;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	`SSG_ASSERT_SAME(a_start_idle, start, state_q == S_IDLE, "block closed while evaluating")
	`SSG_ASSERT_NEXT(a_last_coeff, rot && ci_q == CW'(1), state_q == S_EMIT, "missed emit")
	`SSG_ASSERT_NEXT(a_block_end, state_q == S_EMIT && emit_ok && is_last, state_q == S_IDLE && out_valid_q && share_out.data.last_share, "bad block end")

endmodule

`default_nettype wire

// ===== hw/rtl/shamir_share_generator_unit.sv =====
// Top level of the share generator: registers, coefficient chain, evaluator.
// Usage:
//  coeff_in takes one coefficient word per item, lowest degree first. While
//  no block is being evaluated, ready is high and a word is taken every cycle.
//  When the word that completes a block (threshold coefficients) is taken,
//  ready drops and the polynomial is evaluated by Horner's rule at x = 1..n.
//  share_out gives one word per point, last_share set on point n.
//  Per share, each coefficient takes a bit-serial reduction mod p (a mask
//  in the binary field), five double/add pairs for the multiply by x and
//  one accumulate; the share word is then emitted.
//  Coefficients sit in a chain of K_MAX cells; new words shift in at cell 0
//  and the chain rotates one place per Horner step, back to where it was
//  after each share.
//  A stalled share_out holds its word; the evaluator goes on with the next
//  share and, before emitting it, waits until the held word is taken.
//  Reset (arst_n low) clears the coefficient count, the registers to their
//  defaults and the evaluator to idle; the cells are not cleared.
//  APB: registers at 4*i, writes in the access phase, pready tied high.
`default_nettype none

module shamir_share_generator_unit #(
	parameter int K_MAX = 8,
	parameter int N_MAX = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ssg_stream_if.sink       coeff_in,
	ssg_stream_if.source     share_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int CW = $clog2(K_MAX + 1);

	// configuration registers
	logic        mode_q;
	logic [31:0] p_q;
	logic [5:0]  deg_q;
	logic [31:0] poly_q;
	logic [3:0]  thr_q;
	logic [4:0]  sc_q;

	logic [CW-1:0] count_q;
	logic          wr, accept, close, start, rot, busy;
	logic [CW-1:0] k_eff, used_w, ring_len;
	logic [5:0]    m_eff;
	logic [32:0]   mask_w;
	ssg_pkg::field_cfg_t cfg;
	logic [31:0]   cell_q [K_MAX];

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			p_q    <= 32'd257;
			deg_q  <= 6'd8;
			poly_q <= 32'd27;
			thr_q  <= 4'd3;
			sc_q   <= 5'd5;
		end else if (wr) begin
			unique case (paddr[4:2])
				ssg_pkg::REG_FIELD_MODE:     mode_q <= pwdata[0];
				ssg_pkg::REG_PRIME_MODULUS:  p_q    <= pwdata;
				ssg_pkg::REG_FIELD_DEGREE:   deg_q  <= pwdata[5:0];
				ssg_pkg::REG_REDUCTION_POLY: poly_q <= pwdata;
				ssg_pkg::REG_THRESHOLD:      thr_q  <= pwdata[3:0];
				ssg_pkg::REG_SHARE_COUNT:    sc_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			ssg_pkg::REG_FIELD_MODE:     prdata = {31'd0, mode_q};
			ssg_pkg::REG_PRIME_MODULUS:  prdata = p_q;
			ssg_pkg::REG_FIELD_DEGREE:   prdata = {26'd0, deg_q};
			ssg_pkg::REG_REDUCTION_POLY: prdata = poly_q;
			ssg_pkg::REG_THRESHOLD:      prdata = {28'd0, thr_q};
			ssg_pkg::REG_SHARE_COUNT:    prdata = {27'd0, sc_q};
			default:                     prdata = '0;
		endcase
	end

	// clamped settings: zero acts as one, too large acts as the maximum
	assign k_eff = (thr_q == 4'd0) ? CW'(1) :
		((32'(thr_q) > K_MAX) ? CW'(K_MAX) : CW'(thr_q));
	assign m_eff  = (deg_q == 6'd0) ? 6'd1 : ((deg_q > 6'd32) ? 6'd32 : deg_q);
	assign mask_w = (33'd1 << m_eff) - 33'd1;

	always_comb begin
		cfg.binary  = mode_q;
		cfg.modulus = p_q;
		cfg.degree  = m_eff;
		cfg.mask    = mask_w[31:0];
		cfg.poly    = poly_q & mask_w[31:0];
		cfg.points  = (sc_q == 5'd0) ? 5'd1 :
			((32'(sc_q) > N_MAX) ? 5'(N_MAX) : sc_q);
	end

	// block assembly: a lowered threshold closes on the next word
	assign coeff_in.ready = !busy;
	assign accept = coeff_in.valid && coeff_in.ready;
	assign used_w = count_q + CW'(1);
	assign close  = ({1'b0, count_q} + {{CW{1'b0}}, 1'b1}) >= {1'b0, k_eff};
	assign start  = accept && close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= close ? '0 : used_w;
		end
	end

	// coefficient chain: shift in at cell 0, rotate over the used length
	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		logic [31:0] ld_in, rot_in;
		if (i == 0) begin : g_head
			assign ld_in = coeff_in.data.coeff_value;
		end else begin : g_body
			assign ld_in = cell_q[i-1];
		end
		if (i == K_MAX - 1) begin : g_tail
			assign rot_in = cell_q[0];
		end else begin : g_mid
			assign rot_in = (ring_len == CW'(i + 1)) ? cell_q[0] : cell_q[i+1];
		end
		ssg_cell u_cell (
			.clk    (clk),
			.load   (accept),
			.rot    (rot),
			.ld_in  (ld_in),
			.rot_in (rot_in),
			.q      (cell_q[i])
		);
	end

	ssg_eval #(
		.K_MAX (K_MAX)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.used      (used_w),
		.coeff     (cell_q[0]),
		.rot       (rot),
		.ring_len  (ring_len),
		.busy      (busy),
		.share_out (share_out)
	);

endmodule

`default_nettype wire
